[rtl/debounced_quadrature_encoder_macros.svh]
// Assertion macros used by the encoder top level.
`ifndef DEBOUNCED_QUADRATURE_ENCODER_MACROS_SVH
`define DEBOUNCED_QUADRATURE_ENCODER_MACROS_SVH

// Same-cycle implication, checked on every rising clk edge out of reset.
`define DQE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clk edge out of reset.
`define DQE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/dqe_pkg.sv]
// Package: types, codes and constants of the debounced quadrature encoder.
`timescale 1ns / 1ps

package dqe_pkg;

    localparam int OP_W     = 2;
    localparam int POS_W    = 16;
    localparam int CNT_W    = 16;
    localparam int PRESS_W  = 8;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    // Read prescale, a power of two, so the divide in the top level is a shift with rounding fix.
    localparam int PRESCALE = 4;
    localparam logic signed [POS_W-1:0] PRESCALE_DIV = POS_W'(PRESCALE);

    localparam logic [CNT_W-1:0]   STABLE_SAMPLES_RST = CNT_W'(20);
    localparam logic [CNT_W-1:0]   CNT_MAX            = '1;
    localparam logic [PRESS_W-1:0] PRESS_MAX          = '1;

    typedef enum logic [OP_W-1:0] {
        OP_TICK = 2'd0,
        OP_READ = 2'd1,
        OP_TAKE = 2'd2
    } dqe_op_t;

    typedef enum logic [1:0] {
        MODE_UNSTABLE   = 2'd0,
        MODE_TRANSITION = 2'd1,
        MODE_STABLE     = 2'd2
    } dqe_mode_t;

    // Word index of the configuration registers (paddr[2]).
    localparam logic REG_STABLE_SAMPLES = 1'b0;

    // Debounced view of one line after the current tick.
    typedef struct packed {
        dqe_mode_t mode;
        logic      level;
    } dqe_line_t;

endpackage

[rtl/dqe_if.sv]
// Interfaces: request and result channels with valid/ready handshake.
`timescale 1ns / 1ps

interface dqe_in_if import dqe_pkg::*;;
    logic            valid;
    logic            ready;
    logic [OP_W-1:0] operation;
    logic            line_a;
    logic            line_b;
    logic            button_level;

    modport source (output valid, operation, line_a, line_b, button_level, input ready);
    modport sink   (input valid, operation, line_a, line_b, button_level, output ready);
endinterface

interface dqe_out_if import dqe_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] steps;
    logic                    press_taken;

    modport source (output valid, steps, press_taken, input ready);
    modport sink   (input valid, steps, press_taken, output ready);
endinterface

[rtl/dqe_debounce.sv]
// Three-state debouncer for one sampled line.
`timescale 1ns / 1ps

module dqe_debounce import dqe_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             tick,
    input  logic             level,
    input  logic [CNT_W-1:0] stable_samples,
    output dqe_line_t        line
);

    dqe_mode_t        mode_reg, mode_next;
    logic             last_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        mode_next  = mode_reg;
        count_next = count_reg;
        case (mode_reg)
            MODE_UNSTABLE:
            begin
                if (level == last_reg)
                begin
                    if (count_reg != CNT_MAX)
                        count_next = count_reg + CNT_W'(1);
                end
                else
                begin
                    count_next = '0;
                end
                if (count_next == stable_samples)
                    mode_next = MODE_TRANSITION;
            end
            MODE_TRANSITION:
            begin
                mode_next = MODE_STABLE;
            end
            default:
            begin
                // stable: any level change restarts settling
                if (level != last_reg)
                begin
                    count_next = '0;
                    mode_next  = MODE_UNSTABLE;
                end
            end
        endcase
    end

    assign line.mode  = mode_next;
    assign line.level = level;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_UNSTABLE;
            last_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (tick)
        begin
            mode_reg  <= mode_next;
            last_reg  <= level;
            count_reg <= count_next;
        end
    end

endmodule

[rtl/debounced_quadrature_encoder.sv]
// Top level: debounced rotary encoder with push button, APB configuration.
`timescale 1ns / 1ps

// Debounced quadrature encoder. Each request on req carries an operation:
// a sample tick (line_a, line_b, button_level), a read of the position that
// clears it if the quotient is nonzero, or a take of one pending button press.
// Every request yields exactly one result on rsp: steps holds position / 4
// (truncated toward zero) on a read, press_taken flags a consumed press; both
// are zero otherwise. Throughput is one request per clock while rsp is ready
// or the output register is empty: all state is updated at the accepting
// edge by single-level logic, and the result lands in a single output
// register, valid in the cycle after acceptance. Register 0 at byte address
// 0 is stable_samples (16 bits, reset 20), the count of equal samples a line
// needs to settle; write it only while the block is idle. pready is tied high.

`include "debounced_quadrature_encoder_macros.svh"

module debounced_quadrature_encoder import dqe_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    dqe_in_if.sink             req,
    dqe_out_if.source          rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    // ---------------------------------------------------------------
    // Configuration
    // ---------------------------------------------------------------
    logic [CNT_W-1:0] stable_samples_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_STABLE_SAMPLES);
    assign prdata = (paddr[2] == REG_STABLE_SAMPLES)
                    ? PDATA_W'(stable_samples_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stable_samples_reg <= STABLE_SAMPLES_RST;
        else if (cfg_wr)
            stable_samples_reg <= pwdata[CNT_W-1:0];
    end

    // ---------------------------------------------------------------
    // Request decode
    // ---------------------------------------------------------------
    logic accept, is_tick, is_read, is_take;

    assign req.ready = !rsp.valid || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign is_tick   = (req.operation == OP_TICK);
    assign is_read   = (req.operation == OP_READ);
    assign is_take   = (req.operation == OP_TAKE);

    // ---------------------------------------------------------------
    // Debouncers: A, B and the button advance only on an accepted tick
    // ---------------------------------------------------------------
    dqe_line_t line_a_st, line_b_st, button_st;

    dqe_debounce u_deb_a (
        .clk            (clk),
        .rst_n          (rst_n),
        .tick           (accept && is_tick),
        .level          (req.line_a),
        .stable_samples (stable_samples_reg),
        .line           (line_a_st)
    );

    dqe_debounce u_deb_b (
        .clk            (clk),
        .rst_n          (rst_n),
        .tick           (accept && is_tick),
        .level          (req.line_b),
        .stable_samples (stable_samples_reg),
        .line           (line_b_st)
    );

    dqe_debounce u_deb_btn (
        .clk            (clk),
        .rst_n          (rst_n),
        .tick           (accept && is_tick),
        .level          (req.button_level),
        .stable_samples (stable_samples_reg),
        .line           (button_st)
    );

    // ---------------------------------------------------------------
    // Position count
    // ---------------------------------------------------------------
    logic signed [POS_W-1:0] position_reg, position_next;
    logic signed [POS_W-1:0] quotient;
    logic signed [POS_W:0]   pos_moved;
    logic                    step_up, step_dn, levels_eq;

    assign levels_eq = (line_a_st.level == line_b_st.level);

    // A settling while B holds, or B settling while A holds, is one step.
    always_comb
    begin
        step_up = 1'b0;
        step_dn = 1'b0;
        if (line_a_st.mode == MODE_TRANSITION && line_b_st.mode == MODE_STABLE)
        begin
            step_up = levels_eq;
            step_dn = !levels_eq;
        end
        else if (line_a_st.mode == MODE_STABLE && line_b_st.mode == MODE_TRANSITION)
        begin
            step_up = !levels_eq;
            step_dn = levels_eq;
        end
    end

    // Move one step in a 17-bit sum, so overflow can be saturated at the signed 16-bit limits below.
    always_comb
    begin
        pos_moved = {position_reg[POS_W-1], position_reg};
        if (step_up)
            pos_moved = pos_moved + (POS_W+1)'(1);
        else if (step_dn)
            pos_moved = pos_moved - (POS_W+1)'(1);
    end

    // Divide by a power-of-two constant, truncating toward zero.
    assign quotient = position_reg / PRESCALE_DIV;

    always_comb
    begin
        position_next = position_reg;
        if (is_tick)
        begin
            if (pos_moved[POS_W] != pos_moved[POS_W-1])
                position_next = pos_moved[POS_W] ? {1'b1, {(POS_W-1){1'b0}}}
                                                 : {1'b0, {(POS_W-1){1'b1}}};
            else
                position_next = pos_moved[POS_W-1:0];
        end
        else if (is_read && quotient != '0)
        begin
            position_next = '0;
        end
    end

    // ---------------------------------------------------------------
    // Pending button presses: count falling settles, drop one per take
    // ---------------------------------------------------------------
    logic [PRESS_W-1:0] pending_reg, pending_next;
    logic               press_taken;

    always_comb
    begin
        pending_next = pending_reg;
        press_taken  = 1'b0;
        if (is_tick)
        begin
            if (button_st.mode == MODE_TRANSITION && !button_st.level
                && pending_reg != PRESS_MAX)
                pending_next = pending_reg + PRESS_W'(1);
        end
        else if (is_take && pending_reg != '0)
        begin
            pending_next = pending_reg - PRESS_W'(1);
            press_taken  = 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // State and result register
    // ---------------------------------------------------------------
    logic                    rsp_valid_reg;
    logic signed [POS_W-1:0] steps_reg;
    logic                    press_taken_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg  <= '0;
            pending_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                position_reg <= position_next;
                pending_reg  <= pending_next;
            end
            if (req.ready)
                rsp_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            steps_reg       <= is_read ? quotient : '0;
            press_taken_reg <= press_taken;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.steps       = steps_reg;
    assign rsp.press_taken = press_taken_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `DQE_ASSERT_NOW(a_taken_no_steps, rsp_valid_reg && press_taken_reg, steps_reg == '0,
        "press result carries nonzero steps")
    `DQE_ASSERT_NEXT(a_read_clears, accept && is_read && quotient != '0, position_reg == '0,
        "nonzero read did not clear position")
    `DQE_ASSERT_NEXT(a_take_drops_one, accept && is_take && pending_reg != '0,
        pending_reg == $past(pending_reg) - PRESS_W'(1) && press_taken_reg,
        "take did not consume exactly one press")
    `DQE_ASSERT_NEXT(a_tick_one_step, accept && is_tick,
        position_reg == $past(position_reg)
        || position_reg == $past(position_reg) + POS_W'(1)
        || position_reg == $past(position_reg) - POS_W'(1),
        "tick moved position by more than one step")

endmodule
